// File: sv/msm_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and reset values for the stall and timeout monitor.
package msm_pkg;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	localparam logic [15:0] CMD_TIMEOUT_RST = 16'd500;
	localparam logic [7:0]  PWM_THR_RST     = 8'd50;
	localparam logic [15:0] RPM_THR_RST     = 16'd10;
	localparam logic [15:0] STALL_DUR_RST   = 16'd1000;

	typedef enum logic [1:0] {
		OP_CHECK   = 2'd0,
		OP_COMMAND = 2'd1,
		OP_CLEAR   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ERR_NONE        = 2'd0,
		ERR_TIMEOUT     = 2'd1,
		ERR_STALL_LEFT  = 2'd2,
		ERR_STALL_RIGHT = 2'd3
	} err_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CMD_TIMEOUT = 2'd0,
		REG_PWM_THR     = 2'd1,
		REG_RPM_THR     = 2'd2,
		REG_STALL_DUR   = 2'd3
	} cfg_reg_t;

	// merge stage -> lane
	typedef struct packed {
		logic clear;
		logic commit;
	} lane_ctrl_t;

	// lane -> merge stage
	typedef struct packed {
		logic expire;
	} lane_stat_t;

endpackage

// File: sv/msm_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input items and results.
interface msm_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic [31:0]        now_ms;
	logic [7:0]         drive_a;
	logic [7:0]         drive_b;
	logic signed [15:0] speed_a;
	logic signed [15:0] speed_b;

	modport source (
		output valid, op, now_ms, drive_a, drive_b, speed_a, speed_b,
		input  ready
	);
	modport sink (
		input  valid, op, now_ms, drive_a, drive_b, speed_a, speed_b,
		output ready
	);
endinterface

interface msm_out_if;
	logic       valid;
	logic       ready;
	logic       stop;
	logic [1:0] error_code;

	modport source (
		output valid, stop, error_code,
		input  ready
	);
	modport sink (
		input  valid, stop, error_code,
		output ready
	);
endinterface

// File: sv/msm_stall_lane.sv
`timescale 1ns / 1ps
// One motor's stall detector: condition test and stall timer.
module msm_stall_lane
	import msm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         drive,
	input  logic signed [15:0] speed,
	input  logic [31:0]        now_ms,
	input  logic [7:0]         pwm_thr,
	input  logic [15:0]        rpm_thr,
	input  logic [15:0]        stall_dur,
	input  lane_ctrl_t         ctrl,
	output lane_stat_t         stat
);

	logic        timing_q;
	logic [31:0] since_q;
	logic [16:0] speed_ext;
	logic [16:0] speed_mag;
	logic [31:0] elapsed;
	logic        stalling;
	logic        expire;

	assign speed_ext = {speed[15], speed};
	// -32768 maps to 32768, hence the extra bit
	assign speed_mag = speed[15] ? 17'(-speed_ext) : speed_ext;
	assign stalling  = (drive > pwm_thr) && (speed_mag < {1'b0, rpm_thr});
	assign elapsed   = now_ms - since_q;
	assign expire    = stalling && timing_q && (elapsed > {16'd0, stall_dur});

	assign stat.expire = expire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q <= 1'b0;
		end else if (ctrl.clear) begin
			timing_q <= 1'b0;
		end else if (ctrl.commit) begin
			if (!stalling || expire)
				timing_q <= 1'b0;
			else
				timing_q <= 1'b1;
		end
	end

	// timestamp only matters while timing_q is set
	always_ff @(posedge clk) begin
		if (ctrl.commit && stalling && !timing_q)
			since_q <= now_ms;
	end

endmodule

// File: sv/msm_merge.sv
`timescale 1ns / 1ps
// Timeout check, priority merge of lane results and the error latch.
module msm_merge
	import msm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [1:0]  op,
	input  logic [31:0] now_ms,
	input  logic [15:0] cmd_timeout,
	input  lane_stat_t  stat_a,
	input  lane_stat_t  stat_b,
	output lane_ctrl_t  ctrl_a,
	output lane_ctrl_t  ctrl_b,
	output logic        stop,
	output logic [1:0]  error_code
);

	logic [31:0] last_cmd_q;
	err_t        err_q;
	err_t        err_next;
	logic [31:0] since_cmd;
	logic        timeout;
	logic        is_check;
	logic        is_clear;

	assign since_cmd = now_ms - last_cmd_q;
	assign timeout   = since_cmd > {16'd0, cmd_timeout};
	assign is_check  = op_t'(op) == OP_CHECK;
	assign is_clear  = op_t'(op) == OP_CLEAR;

	// an earlier stop skips the later lanes, leaving their timers alone
	assign ctrl_a.clear  = accept && is_clear;
	assign ctrl_b.clear  = accept && is_clear;
	assign ctrl_a.commit = accept && is_check && !timeout;
	assign ctrl_b.commit = accept && is_check && !timeout && !stat_a.expire;

	always_comb begin
		err_next = err_q;
		unique case (op_t'(op))
			OP_CLEAR: err_next = ERR_NONE;
			OP_CHECK: begin
				if (timeout)
					err_next = ERR_TIMEOUT;
				else if (stat_a.expire)
					err_next = ERR_STALL_LEFT;
				else if (stat_b.expire)
					err_next = ERR_STALL_RIGHT;
			end
			default: err_next = err_q;
		endcase
	end

	assign stop       = is_check && (timeout || stat_a.expire || stat_b.expire);
	assign error_code = err_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cmd_q <= '0;
			err_q      <= ERR_NONE;
		end else if (accept) begin
			err_q <= err_next;
			if (op_t'(op) == OP_COMMAND)
				last_cmd_q <= now_ms;
		end
	end

endmodule

// File: sv/motor_stall_and_timeout_monitor_core.sv
`timescale 1ns / 1ps
// Each result is registered in the output register, or in the skid entry while
// out_ch is held. Throughput: one item per cycle while the skid is empty;
// all state updates in the accept cycle, and both stall lanes work in parallel
// with the timeout check in the merge. A two-entry output register (main plus
// skid) keeps in_ch ready while one result waits. Reset clears timers, error
// latch and command time, and loads the default thresholds; no clearing pass.
module motor_stall_and_timeout_monitor_core
	import msm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	msm_in_if.sink                in_ch,
	msm_out_if.source             out_ch
);

	logic [15:0] cmd_timeout_q;
	logic [7:0]  pwm_thr_q;
	logic [15:0] rpm_thr_q;
	logic [15:0] stall_dur_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_timeout_q <= CMD_TIMEOUT_RST;
			pwm_thr_q     <= PWM_THR_RST;
			rpm_thr_q     <= RPM_THR_RST;
			stall_dur_q   <= STALL_DUR_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_CMD_TIMEOUT: cmd_timeout_q <= cfg_wdata;
				REG_PWM_THR:     pwm_thr_q     <= cfg_wdata[7:0];
				REG_RPM_THR:     rpm_thr_q     <= cfg_wdata;
				REG_STALL_DUR:   stall_dur_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic       accept;
	lane_ctrl_t ctrl_a, ctrl_b;
	lane_stat_t stat_a, stat_b;
	logic       res_stop;
	logic [1:0] res_err;

	logic       out_valid_q, skid_valid_q;
	logic       out_stop_q, skid_stop_q;
	logic [1:0] out_err_q, skid_err_q;
	logic       out_free;

	assign in_ch.ready = !skid_valid_q;
	assign accept      = in_ch.valid && in_ch.ready;

	msm_stall_lane u_lane_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.drive     (in_ch.drive_a),
		.speed     (in_ch.speed_a),
		.now_ms    (in_ch.now_ms),
		.pwm_thr   (pwm_thr_q),
		.rpm_thr   (rpm_thr_q),
		.stall_dur (stall_dur_q),
		.ctrl      (ctrl_a),
		.stat      (stat_a)
	);

	msm_stall_lane u_lane_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.drive     (in_ch.drive_b),
		.speed     (in_ch.speed_b),
		.now_ms    (in_ch.now_ms),
		.pwm_thr   (pwm_thr_q),
		.rpm_thr   (rpm_thr_q),
		.stall_dur (stall_dur_q),
		.ctrl      (ctrl_b),
		.stat      (stat_b)
	);

	msm_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.op          (in_ch.op),
		.now_ms      (in_ch.now_ms),
		.cmd_timeout (cmd_timeout_q),
		.stat_a      (stat_a),
		.stat_b      (stat_b),
		.ctrl_a      (ctrl_a),
		.ctrl_b      (ctrl_b),
		.stop        (res_stop),
		.error_code  (res_err)
	);

	assign out_free = !out_valid_q || out_ch.ready;

	// skid entry is older than any new transaction, so it drains first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || accept;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_stop_q <= skid_stop_q;
				out_err_q  <= skid_err_q;
			end else if (accept) begin
				out_stop_q <= res_stop;
				out_err_q  <= res_err;
			end
		end else if (accept) begin
			skid_stop_q <= res_stop;
			skid_err_q  <= res_err;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.stop       = out_stop_q;
	assign out_ch.error_code = out_err_q;

endmodule

// File: tb/msm_verdict_monitor.sv
`timescale 1ns / 1ps
// Channel monitor: predicts each stop/error verdict and compares the results.
module msm_verdict_monitor
	import msm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	msm_in_if                     in_ch,
	msm_out_if                    out_ch,
	output int                    fail_count,
	output int                    pending
);
	typedef struct packed {
		logic stop;
		err_t err;
	} verdict_t;

	logic [15:0] timeout_ms;
	logic [7:0]  pwm_thr;
	logic [15:0] rpm_thr;
	logic [15:0] stall_ms;

	logic [31:0] last_cmd_ms;
	logic [31:0] stall_start [2];
	logic        stall_armed [2];
	err_t        err_latch;

	verdict_t expected_verdicts [$];
	int       fails;

	function automatic void disarm_lane(input int lane);
		stall_armed[lane] = 1'b0;
		stall_start[lane] = '0;
	endfunction

	// Runs one motor's stall timer; returns 1 when the stall has lasted too long.
	function automatic logic lane_expired(input int lane, input logic [7:0] drive,
		input logic signed [15:0] speed, input logic [31:0] now);
		logic [16:0] mag;
		logic [31:0] held;
		mag = speed[15] ? 17'h10000 - {1'b0, speed} : {1'b0, speed};
		if (drive > pwm_thr && mag < {1'b0, rpm_thr}) begin
			if (!stall_armed[lane]) begin
				stall_armed[lane] = 1'b1;
				stall_start[lane] = now;
			end else begin
				held = now - stall_start[lane];
				if (held > {16'd0, stall_ms}) begin
					disarm_lane(lane);
					return 1'b1;
				end
			end
		end else begin
			disarm_lane(lane);
		end
		return 1'b0;
	endfunction

	function automatic verdict_t judge_item(input logic [1:0] op, input logic [31:0] now,
		input logic [7:0] drive_a, input logic [7:0] drive_b,
		input logic signed [15:0] speed_a, input logic signed [15:0] speed_b);
		verdict_t    v;
		logic [31:0] since_cmd;
		v.stop = 1'b0;
		since_cmd = now - last_cmd_ms;
		case (op)
			OP_COMMAND: last_cmd_ms = now;
			OP_CLEAR: begin
				err_latch = ERR_NONE;
				disarm_lane(0);
				disarm_lane(1);
			end
			OP_CHECK: begin
				// timeout wins, then motor A, then motor B; first hit skips the rest
				if (since_cmd > {16'd0, timeout_ms}) begin
					err_latch = ERR_TIMEOUT;
					v.stop = 1'b1;
				end else if (lane_expired(0, drive_a, speed_a, now)) begin
					err_latch = ERR_STALL_LEFT;
					v.stop = 1'b1;
				end else if (lane_expired(1, drive_b, speed_b, now)) begin
					err_latch = ERR_STALL_RIGHT;
					v.stop = 1'b1;
				end
			end
			default: ;
		endcase
		v.err = err_latch;
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		verdict_t want;
		if (!arst_n) begin
			timeout_ms = CMD_TIMEOUT_RST;
			pwm_thr = PWM_THR_RST;
			rpm_thr = RPM_THR_RST;
			stall_ms = STALL_DUR_RST;
			last_cmd_ms = '0;
			disarm_lane(0);
			disarm_lane(1);
			err_latch = ERR_NONE;
			expected_verdicts.delete();
			fails = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			// result side first: a result never belongs to an item accepted at the same edge
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
				if (expected_verdicts.size() == 0) begin
					$error("unexpected result: stop %0d, error_code %0d",
						out_ch.stop, out_ch.error_code);
					fails++;
				end else begin
					want = expected_verdicts.pop_front();
					if (out_ch.stop !== want.stop) begin
						$error("stop mismatch: expected %0d, actual %0d", want.stop, out_ch.stop);
						fails++;
					end
					if (out_ch.error_code !== want.err) begin
						$error("error_code mismatch: expected %0d, actual %0d",
							want.err, out_ch.error_code);
						fails++;
					end
				end
			end
			if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
				expected_verdicts.push_back(judge_item(in_ch.op, in_ch.now_ms, in_ch.drive_a,
					in_ch.drive_b, in_ch.speed_a, in_ch.speed_b));
			if (cfg_we === 1'b1) begin
				case (cfg_idx)
					REG_CMD_TIMEOUT: timeout_ms = cfg_wdata;
					REG_PWM_THR:     pwm_thr = cfg_wdata[7:0];
					REG_RPM_THR:     rpm_thr = cfg_wdata;
					REG_STALL_DUR:   stall_ms = cfg_wdata;
					default: ;
				endcase
			end
			fail_count <= fails;
			pending <= expected_verdicts.size();
		end
	end

endmodule

// File: tb/motor_stall_and_timeout_monitor_core_tb.sv
`timescale 1ns / 1ps
// Top of the stall and timeout monitor testbench: clock, reset, stimulus and verdict.
module motor_stall_and_timeout_monitor_core_tb;
	import msm_pkg::*;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         IDLE_LIMIT  = 2000;
	localparam int         PHASES      = 12;
	localparam int         PHASE_ITEMS = 120;

	typedef struct {
		logic [1:0]         op;
		logic [31:0]        now_ms;
		logic [7:0]         drive_a;
		logic [7:0]         drive_b;
		logic signed [15:0] speed_a;
		logic signed [15:0] speed_b;
	} motor_sample_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = REG_CMD_TIMEOUT;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	int fail_count;
	int pending;
	int idle_cycles = 0;

	logic        quiet_link = 1'b0;
	logic [15:0] timeout_ms = CMD_TIMEOUT_RST;
	logic [7:0]  pwm_thr = PWM_THR_RST;
	logic [15:0] rpm_thr = RPM_THR_RST;
	logic [15:0] stall_ms = STALL_DUR_RST;
	logic [31:0] clock_ms = '0;

	msm_in_if  in_ch ();
	msm_out_if out_ch ();

	motor_stall_and_timeout_monitor_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	msm_verdict_monitor verdict_mon (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always #2 clk = ~clk;

	function automatic int draw_gap();
		return quiet_link ? 0 : int'($urandom_range(0, 5));
	endfunction

	function automatic logic [7:0] pick_drive();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return pwm_thr;
		if (r == 1 || pwm_thr == 8'd255)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(int'(pwm_thr) + 1, 255));
	endfunction

	function automatic logic signed [15:0] pick_speed();
		int                 r;
		logic [16:0]        mag;
		logic signed [15:0] v;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 16'h8000;
		if (r == 1)
			return 16'($urandom);
		if (r == 2)
			mag = {1'b0, rpm_thr};
		else
			mag = 17'($urandom_range(0, rpm_thr == 16'd0 ? 0 : int'(rpm_thr) - 1));
		v = mag[15:0];
		if ($urandom_range(0, 1) == 1)
			v = -v;
		return v;
	endfunction

	// Mostly a running session with advancing time; some pure noise.
	function automatic motor_sample_t next_sample();
		motor_sample_t s;
		int            r;
		int unsigned   step;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			s.op = 2'($urandom_range(0, 3));
			s.now_ms = $urandom;
			s.drive_a = 8'($urandom);
			s.drive_b = 8'($urandom);
			s.speed_a = 16'($urandom);
			s.speed_b = 16'($urandom);
			return s;
		end
		if ($urandom_range(0, 19) == 0)
			step = $urandom_range(0, int'(timeout_ms) + int'(stall_ms) + 20);
		else
			step = $urandom_range(0, int'(stall_ms) / 3 + 3);
		clock_ms += step;
		r = $urandom_range(0, 99);
		if (r < 18)
			s.op = OP_COMMAND;
		else if (r < 22)
			s.op = OP_CLEAR;
		else if (r < 24)
			s.op = OP_UNUSED;
		else
			s.op = OP_CHECK;
		s.now_ms = clock_ms;
		s.drive_a = pick_drive();
		s.drive_b = pick_drive();
		s.speed_a = pick_speed();
		s.speed_b = pick_speed();
		return s;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_sample(input motor_sample_t s);
		int gap;
		gap = draw_gap();
		if (gap != 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.op = s.op;
		in_ch.now_ms = s.now_ms;
		in_ch.drive_a = s.drive_a;
		in_ch.drive_b = s.drive_b;
		in_ch.speed_a = s.speed_a;
		in_ch.speed_b = s.speed_b;
		in_ch.valid = 1'b1;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		@(negedge clk);
	endtask

	task automatic send_fields(input logic [1:0] op, input logic [31:0] now,
		input logic [7:0] da, input logic [7:0] db,
		input logic signed [15:0] sa, input logic signed [15:0] sb);
		motor_sample_t s;
		s = '{op, now, da, db, sa, sb};
		send_sample(s);
	endtask

	task automatic apply_thresholds(input logic [15:0] t, input logic [7:0] p,
		input logic [15:0] r, input logic [15:0] d);
		timeout_ms = t;
		pwm_thr = p;
		rpm_thr = r;
		stall_ms = d;
		cfg_we = 1'b1;
		cfg_idx = REG_CMD_TIMEOUT;
		cfg_wdata = t;
		@(negedge clk);
		cfg_idx = REG_PWM_THR;
		cfg_wdata = {8'd0, p};
		@(negedge clk);
		cfg_idx = REG_RPM_THR;
		cfg_wdata = r;
		@(negedge clk);
		cfg_idx = REG_STALL_DUR;
		cfg_wdata = d;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Wait for every expected result, then add a margin.
	task automatic settle();
		in_ch.valid = 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.op = OP_CHECK;
		in_ch.now_ms = '0;
		in_ch.drive_a = '0;
		in_ch.drive_b = '0;
		in_ch.speed_a = '0;
		in_ch.speed_b = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part, reset thresholds: timeout 500, pwm 50, rpm 10, duration 1000
		send_fields(OP_CHECK, 32'd0, 8'd0, 8'd0, 16'sd0, 16'sd0);
		send_fields(OP_CHECK, 32'hFFFF_FFFF, 8'd255, 8'd255, 16'sd32767, 16'sh8000);
		send_fields(OP_UNUSED, 32'd1234, 8'd255, 8'd255, 16'sd0, 16'sd0);
		send_fields(OP_CLEAR, 32'd0, 8'd0, 8'd0, 16'sd0, 16'sd0);
		send_fields(OP_COMMAND, 32'd1000, 8'd0, 8'd0, 16'sd0, 16'sd0);
		// most negative speed counts as fast; motor B starts its stall timer
		send_fields(OP_CHECK, 32'd1000, 8'd255, 8'd51, 16'sh8000, 16'sd9);
		send_fields(OP_CHECK, 32'd1400, 8'd50, 8'd51, 16'sd0, -16'sd9);
		send_fields(OP_CHECK, 32'd1500, 8'd255, 8'd51, 16'sd0, 16'sd9);
		send_fields(OP_COMMAND, 32'd2000, 8'd0, 8'd0, 16'sd0, 16'sd0);
		send_fields(OP_CHECK, 32'd2001, 8'd255, 8'd51, 16'sd0, 16'sd9);
		send_fields(OP_CHECK, 32'd2002, 8'd255, 8'd51, 16'sd10, 16'sd9);
		send_fields(OP_CHECK, 32'd2003, 8'd255, 8'd51, -16'sd9, 16'sd9);
		send_fields(OP_COMMAND, 32'd2900, 8'd0, 8'd0, 16'sd0, 16'sd0);
		send_fields(OP_CHECK, 32'd3004, 8'd255, 8'd51, 16'sd0, 16'sd0);
		send_fields(OP_CHECK, 32'd3005, 8'd0, 8'd51, 16'sd0, 16'sd0);
		send_fields(OP_CLEAR, 32'd3006, 8'd0, 8'd0, 16'sd0, 16'sd0);
		// command time just before the wrap, checks just after it
		send_fields(OP_COMMAND, 32'hFFFF_FF00, 8'd0, 8'd0, 16'sd0, 16'sd0);
		send_fields(OP_CHECK, 32'h0000_00F0, 8'd0, 8'd0, 16'sd0, 16'sd0);
		send_fields(OP_CHECK, 32'h0000_00F5, 8'd0, 8'd0, 16'sd0, 16'sd0);
		send_fields(OP_COMMAND, 32'h8000_0000, 8'hAA, 8'h55, 16'sh5555, 16'shAAAA);
		send_fields(OP_CHECK, 32'h8000_0000, 8'hAA, 8'h55, 16'sh5555, 16'shAAAA);
		settle();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: apply_thresholds(16'd0, 8'd0, 16'd32768, 16'd0);
				1: apply_thresholds(16'd65535, 8'd255, 16'd0, 16'd65535);
				2: apply_thresholds(16'd65535, 8'd0, 16'd32768, 16'd65535);
				3: apply_thresholds(CMD_TIMEOUT_RST, PWM_THR_RST, RPM_THR_RST, STALL_DUR_RST);
				default: apply_thresholds(16'($urandom_range(0, 2000)),
					8'($urandom_range(0, 254)), 16'($urandom_range(0, 3000)),
					16'($urandom_range(0, 1500)));
			endcase
			if (phase % 2 == 1)
				clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
			else
				clock_ms = $urandom;
			quiet_link = (phase % 4 == 3);
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_sample(next_sample());
			settle();
		end

		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		int gap;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = draw_gap();
			if (gap != 0) begin
				out_ch.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ch.ready = 1'b1;
			do @(posedge clk); while (out_ch.valid !== 1'b1);
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
			(out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("status: fail");
		$finish;
	end

endmodule
